// ===== rtl/ldf_pkg.sv =====
`default_nettype none
package ldf_pkg;

	// Packet framing
	localparam int unsigned PKT_LEN = 22;
	localparam int unsigned POS_W = 5;
	localparam logic [POS_W-1:0] POS_LAST = 5'd21;
	localparam logic [POS_W-1:0] POS_CSUM_LO = 5'd20;
	localparam logic [7:0] START_BYTE = 8'hFA;
	localparam logic [7:0] INDEX_LOW = 8'hA0;

	// Checksum
	localparam int unsigned SUM_W = 27;
	localparam int unsigned FOLD_W = 15;

	// Field widths
	localparam int unsigned ANGLE_W = 9;
	localparam int unsigned DIST_W = 14;
	localparam int unsigned WORD_W = 16;
	localparam int unsigned CNT_W = 16;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle_base;
		logic [WORD_W-1:0]  speed_raw;
		logic [DIST_W-1:0]  distance_0;
		logic               invalid_0;
		logic [DIST_W-1:0]  distance_1;
		logic               invalid_1;
		logic [DIST_W-1:0]  distance_2;
		logic               invalid_2;
		logic [DIST_W-1:0]  distance_3;
		logic               invalid_3;
		logic [CNT_W-1:0]   accepted_count;
	} res_t;

endpackage
`default_nettype wire

// ===== rtl/ldf_rx_if.sv =====
`default_nettype none
interface ldf_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/ldf_res_if.sv =====
`default_nettype none
interface ldf_res_if;
	logic                          valid;
	logic                          ready;
	logic [ldf_pkg::ANGLE_W-1:0]   angle_base;
	logic [ldf_pkg::WORD_W-1:0]    speed_raw;
	logic [ldf_pkg::DIST_W-1:0]    distance_0;
	logic                          invalid_0;
	logic [ldf_pkg::DIST_W-1:0]    distance_1;
	logic                          invalid_1;
	logic [ldf_pkg::DIST_W-1:0]    distance_2;
	logic                          invalid_2;
	logic [ldf_pkg::DIST_W-1:0]    distance_3;
	logic                          invalid_3;
	logic [ldf_pkg::CNT_W-1:0]     accepted_count;

	modport source (
		output valid, output angle_base, output speed_raw,
		output distance_0, output invalid_0, output distance_1, output invalid_1,
		output distance_2, output invalid_2, output distance_3, output invalid_3,
		output accepted_count, input ready
	);
	modport sink (
		input valid, input angle_base, input speed_raw,
		input distance_0, input invalid_0, input distance_1, input invalid_1,
		input distance_2, input invalid_2, input distance_3, input invalid_3,
		input accepted_count, output ready
	);
endinterface
`default_nettype wire

// ===== rtl/ldf_frame.sv =====
`default_nettype none
module ldf_frame (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          take,
	input  wire logic [7:0]    rx_byte,
	output logic               last_pending,
	output logic               res_fire,
	output ldf_pkg::res_t      res
);

	logic                          in_pkt_q;
	logic [ldf_pkg::POS_W-1:0]     cnt_q;
	logic [7:0]                    prev_q;
	logic [7:0]                    pkt_q [1:20];
	logic [ldf_pkg::SUM_W-1:0]     sum_q;
	logic [ldf_pkg::CNT_W-1:0]     good_q;

	logic                          starting;
	logic                          active;
	logic [ldf_pkg::POS_W-1:0]     pos;
	logic                          is_last;
	logic [ldf_pkg::FOLD_W-1:0]    fold_sum;
	logic [ldf_pkg::WORD_W-1:0]    csum_word;
	logic                          csum_ok;
	logic                          idx_ok;
	logic [6:0]                    idx_off;
	logic [ldf_pkg::SUM_W-1:0]     sum_next;

	// Byte position within the packet
	assign starting = !in_pkt_q && (rx_byte == ldf_pkg::START_BYTE);
	assign active   = in_pkt_q || starting;
	assign pos      = in_pkt_q ? cnt_q : '0;
	assign is_last  = in_pkt_q && (cnt_q == ldf_pkg::POS_LAST);
	assign last_pending = is_last;

	// Running sum: shift left, add the word closed by this odd byte
	assign sum_next = {sum_q[ldf_pkg::SUM_W-2:0], 1'b0}
		+ ldf_pkg::SUM_W'({rx_byte, prev_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pkt_q <= 1'b0;
			cnt_q    <= '0;
			sum_q    <= '0;
			good_q   <= '0;
		end else if (take && active) begin
			if (is_last) begin
				in_pkt_q <= 1'b0;
				cnt_q    <= '0;
			end else begin
				in_pkt_q <= 1'b1;
				cnt_q    <= pos + 1'b1;
			end
			if (starting) begin
				sum_q <= '0;
			end else if (pos[0] && (pos < ldf_pkg::POS_CSUM_LO)) begin
				sum_q <= sum_next;
			end
			if (res_fire) begin
				good_q <= good_q + 1'b1;
			end
		end
	end

	// Byte store, all bytes but the start byte and the final byte
	always_ff @(posedge clk) begin
		if (take && active) begin
			prev_q <= rx_byte;
			if ((pos != '0) && (pos <= ldf_pkg::POS_CSUM_LO)) begin
				pkt_q[pos] <= rx_byte;
			end
		end
	end

	// Checksum fold and index range check on the final byte
	assign fold_sum  = sum_q[ldf_pkg::FOLD_W-1:0]
		+ ldf_pkg::FOLD_W'(sum_q[ldf_pkg::SUM_W-1:ldf_pkg::FOLD_W]);
	assign csum_word = {rx_byte, pkt_q[20]};
	assign csum_ok   = csum_word == {1'b0, fold_sum};
	assign idx_ok    = (pkt_q[1] >= ldf_pkg::INDEX_LOW) && (pkt_q[1] < ldf_pkg::START_BYTE);
	assign idx_off   = 7'(pkt_q[1] - ldf_pkg::INDEX_LOW);
	assign res_fire  = take && is_last && csum_ok && idx_ok;

	// Result fields
	always_comb begin
		res.angle_base     = {idx_off, 2'b00};
		res.speed_raw      = {pkt_q[3], pkt_q[2]};
		res.distance_0     = {pkt_q[5][5:0], pkt_q[4]};
		res.invalid_0      = pkt_q[5][7];
		res.distance_1     = {pkt_q[9][5:0], pkt_q[8]};
		res.invalid_1      = pkt_q[9][7];
		res.distance_2     = {pkt_q[13][5:0], pkt_q[12]};
		res.invalid_2      = pkt_q[13][7];
		res.distance_3     = {pkt_q[17][5:0], pkt_q[16]};
		res.invalid_3      = pkt_q[17][7];
		res.accepted_count = good_q + 1'b1;
	end

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ldf_pkg::POS_LAST)
		else $error("byte count past packet end");
	a_idle_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		!in_pkt_q |-> (cnt_q == '0))
		else $error("byte count nonzero while idle");
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(take && is_last) |=> !in_pkt_q)
		else $error("packet not closed after final byte");
	a_fire_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_fire |=> (good_q == $past(good_q) + 1'b1))
		else $error("packet count did not advance");
`endif

endmodule
`default_nettype wire

// ===== rtl/ldf_out_reg.sv =====
`default_nettype none
module ldf_out_reg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  wire ldf_pkg::res_t res_in,
	output logic               can_load,
	ldf_res_if.source          res
);

	logic          valid_q;
	ldf_pkg::res_t data_q;

	assign can_load = !valid_q || res.ready;

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res_in;
		end
	end

	assign res.valid          = valid_q;
	assign res.angle_base     = data_q.angle_base;
	assign res.speed_raw      = data_q.speed_raw;
	assign res.distance_0     = data_q.distance_0;
	assign res.invalid_0      = data_q.invalid_0;
	assign res.distance_1     = data_q.distance_1;
	assign res.invalid_1      = data_q.invalid_1;
	assign res.distance_2     = data_q.distance_2;
	assign res.invalid_2      = data_q.invalid_2;
	assign res.distance_3     = data_q.distance_3;
	assign res.invalid_3      = data_q.invalid_3;
	assign res.accepted_count = data_q.accepted_count;

`ifndef NO_ASSERTIONS
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> can_load)
		else $error("result loaded over an untaken beat");
`endif

endmodule
`default_nettype wire

// ===== rtl/lidar_packet_deframer.sv =====
`default_nettype none
// Lidar packet deframer. Takes one serial byte per beat on rx; a 0xFA byte
// while idle opens a 22-byte packet. The 16-bit checksum and the index byte
// are checked on the final byte, and a good packet gives one beat on res with
// angle base, speed word, four distance readings and the running packet count;
// bad packets vanish. rx can take a byte each cycle while rx.ready is high.
// A single result register sits on the output, so rx.ready drops only when the
// final byte of a packet is due while a previous result still waits.
module lidar_packet_deframer (
	input  wire logic clk,
	input  wire logic arst_n,
	ldf_rx_if.sink    rx,
	ldf_res_if.source res
);

	logic          take;
	logic          last_pending;
	logic          res_fire;
	logic          can_load;
	ldf_pkg::res_t frame_res;

	assign rx.ready = !last_pending || can_load;
	assign take     = rx.valid && rx.ready;

	ldf_frame u_frame (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.rx_byte      (rx.rx_byte),
		.last_pending (last_pending),
		.res_fire     (res_fire),
		.res          (frame_res)
	);

	ldf_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (res_fire),
		.res_in   (frame_res),
		.can_load (can_load),
		.res      (res)
	);

endmodule
`default_nettype wire

// ===== bench/lidar_packet_deframer_tb.sv =====
`default_nettype none
module lidar_packet_deframer_tb;
	import ldf_pkg::*;

	// Tracks the byte stream, predicts accepted packets and checks result beats
	class deframe_scoreboard;
		bit              in_frame;
		bit [POS_W-1:0]  frame_pos;
		bit [7:0]        frame [PKT_LEN];
		bit [SUM_W-1:0]  csum_acc;
		bit [CNT_W-1:0]  good_cnt;
		res_t            expected_q [$];
		int              errors;

		function bit [WORD_W-1:0] word_at(int unsigned p);
			return {frame[p+1], frame[p]};
		endfunction

		// One accepted rx beat; queues a result when it closes a good packet
		function void note_byte(bit [7:0] b);
			bit [FOLD_W-1:0]  folded;
			bit [7:0]         idx;
			bit [WORD_W-1:0]  rd;
			res_t             r;
			if (!in_frame) begin
				if (b != START_BYTE)
					return;
				in_frame = 1'b1;
				frame_pos = '0;
				csum_acc = '0;
			end
			frame[frame_pos] = b;
			// words 0..9 feed the shifted running sum
			if (frame_pos[0] && frame_pos < POS_CSUM_LO)
				csum_acc = (csum_acc << 1) + word_at(frame_pos - 1);
			if (frame_pos != POS_LAST) begin
				frame_pos++;
				return;
			end
			in_frame = 1'b0;
			frame_pos = '0;
			folded = csum_acc[FOLD_W-1:0] + csum_acc[SUM_W-1:FOLD_W];
			idx = frame[1];
			if ({1'b0, folded} != word_at(POS_CSUM_LO) || idx < INDEX_LOW
					|| idx >= START_BYTE)
				return;
			good_cnt++;
			r.angle_base = (idx - INDEX_LOW) << 2;
			r.speed_raw = word_at(2);
			rd = word_at(4);
			r.distance_0 = rd[DIST_W-1:0];
			r.invalid_0 = rd[WORD_W-1];
			rd = word_at(8);
			r.distance_1 = rd[DIST_W-1:0];
			r.invalid_1 = rd[WORD_W-1];
			rd = word_at(12);
			r.distance_2 = rd[DIST_W-1:0];
			r.invalid_2 = rd[WORD_W-1];
			rd = word_at(16);
			r.distance_3 = rd[DIST_W-1:0];
			r.invalid_3 = rd[WORD_W-1];
			r.accepted_count = good_cnt;
			expected_q.push_back(r);
		endfunction

		function void match(string fname, int unsigned exp, int unsigned act);
			if (exp != act) begin
				$display("%0t: %s expected %0h actual %0h", $time, fname, exp, act);
				errors++;
			end
		endfunction

		function void check_result(res_t got);
			res_t exp;
			if (expected_q.size() == 0) begin
				$display("%0t: result beat with no packet pending, actual %h", $time, got);
				errors++;
				return;
			end
			exp = expected_q.pop_front();
			match("angle_base", exp.angle_base, got.angle_base);
			match("speed_raw", exp.speed_raw, got.speed_raw);
			match("distance_0", exp.distance_0, got.distance_0);
			match("invalid_0", exp.invalid_0, got.invalid_0);
			match("distance_1", exp.distance_1, got.distance_1);
			match("invalid_1", exp.invalid_1, got.invalid_1);
			match("distance_2", exp.distance_2, got.distance_2);
			match("invalid_2", exp.invalid_2, got.invalid_2);
			match("distance_3", exp.distance_3, got.distance_3);
			match("invalid_3", exp.invalid_3, got.invalid_3);
			match("accepted_count", exp.accepted_count, got.accepted_count);
		endfunction
	endclass

	typedef bit [7:0] frame_t [PKT_LEN];

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   stall_pct;
	int   bytes_sent;

	ldf_rx_if  rx ();
	ldf_res_if res ();

	deframe_scoreboard sb = new();

	lidar_packet_deframer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.res    (res)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("lidar_packet_deframer test failed");
		$finish;
	end

	// Result side: random backpressure and checking of every beat
	always @(posedge clk) begin
		res.ready <= ($urandom_range(99) >= stall_pct);
		if (arst_n && res.valid && res.ready)
			sb.check_result(res_t'({res.angle_base, res.speed_raw,
				res.distance_0, res.invalid_0, res.distance_1, res.invalid_1,
				res.distance_2, res.invalid_2, res.distance_3, res.invalid_3,
				res.accepted_count}));
	end

	// Drive one byte beat, with random idle cycles ahead of it
	task automatic send_byte(input bit [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			rx.valid <= 1'b0;
			rx.rx_byte <= 8'($urandom);
			@(posedge clk);
		end
		rx.valid <= 1'b1;
		rx.rx_byte <= b;
		@(posedge clk);
		while (!rx.ready)
			@(posedge clk);
		sb.note_byte(b);
	endtask

	// Assemble a packet with a correct checksum word
	function automatic frame_t build_frame(bit [7:0] idx, bit [15:0] speed,
			bit [15:0] r0, bit [15:0] r1, bit [15:0] r2, bit [15:0] r3);
		frame_t          f;
		bit [SUM_W-1:0]  s;
		bit [FOLD_W-1:0] fold;
		f[0] = START_BYTE;
		f[1] = idx;
		{f[3], f[2]} = speed;
		{f[5], f[4]} = r0;
		{f[9], f[8]} = r1;
		{f[13], f[12]} = r2;
		{f[17], f[16]} = r3;
		// signal strength bytes
		for (int i = 6; i < 20; i++)
			if (i % 4 == 2 || i % 4 == 3)
				f[i] = ($urandom_range(7) == 0) ? START_BYTE : 8'($urandom);
		s = '0;
		for (int w = 0; w < 10; w++)
			s = (s << 1) + {f[2*w+1], f[2*w]};
		fold = s[FOLD_W-1:0] + s[SUM_W-1:FOLD_W];
		{f[21], f[20]} = {1'b0, fold};
		return f;
	endfunction

	task automatic send_frame(input frame_t f);
		for (int i = 0; i < PKT_LEN; i++) begin
			send_byte(f[i]);
			bytes_sent++;
		end
	endtask

	function automatic bit [15:0] rand_word();
		bit [15:0] w;
		w = 16'($urandom);
		if ($urandom_range(7) == 0)
			w[7:0] = START_BYTE;
		if ($urandom_range(7) == 0)
			w[15:8] = START_BYTE;
		return w;
	endfunction

	initial begin
		frame_t     f;
		bit [7:0]   idx;
		bit [7:0]   noise;
		int unsigned pick;
		int         waited;

		arst_n = 1'b0;
		rx.valid = 1'b0;
		rx.rx_byte = '0;
		res.ready = 1'b0;
		send_idle_pct = 26;
		stall_pct = 61;
		bytes_sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: idle noise at both extremes, then packets with the top and bottom index,
		// start bytes in their data, invalid readings and distance extremes
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame(build_frame(8'hF9, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h3FFF,
			16'h40FA));
		send_frame(build_frame(INDEX_LOW, 16'h0000, 16'hFAFA, 16'h8000, 16'h7FFF,
			16'hC001));

		// Random: mostly good packets, some with a bad index or a bad checksum,
		// with stray bytes between packets
		while (bytes_sent < 950) begin
			if (bytes_sent < 317) begin
				send_idle_pct = 26;
				stall_pct = 61;
			end else if (bytes_sent < 634) begin
				send_idle_pct = 61;
				stall_pct = 26;
			end else begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			while ($urandom_range(99) < 30) begin
				do noise = 8'($urandom); while (noise == START_BYTE);
				send_byte(noise);
			end
			pick = $urandom_range(3);
			idx = (pick == 0) ? INDEX_LOW : (pick == 1) ? 8'hF9
				: 8'($urandom_range(8'hF9, INDEX_LOW));
			f = build_frame(idx, rand_word(), rand_word(), rand_word(), rand_word(),
				rand_word());
			pick = $urandom_range(99);
			if (pick < 7) begin
				// index outside the angle range
				f[1] = ($urandom_range(1) == 0) ? 8'($urandom_range(8'h9F, 0))
					: 8'($urandom_range(8'hFF, START_BYTE));
			end else if (pick < 11) begin
				f[21][7] = 1'b1;
			end else if (pick < 15) begin
				f[20 + $urandom_range(1)][$urandom_range(6)] ^= 1'b1;
			end
			send_frame(f);
		end
		rx.valid <= 1'b0;

		waited = 0;
		while (sb.expected_q.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (sb.expected_q.size() != 0) begin
			$display("%0t: %0d packets expected but never output", $time,
				sb.expected_q.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("lidar_packet_deframer test passed");
		else
			$display("lidar_packet_deframer test failed");
		$finish;
	end

endmodule
`default_nettype wire
